/* hw/rtl/b64e_pkg.sv */
package b64e_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned SextW  = 6;
	localparam int unsigned GroupN = 4;

	// One encoded group on its way from the group stage to the serializer.
	typedef struct packed {
		logic [GroupN-1:0][ByteW-1:0] chars;
		logic [1:0]                   n_m1;
		logic                         fin;
	} grp_t;

	// Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
	function automatic logic [ByteW-1:0] sym(input logic [SextW-1:0] v);
		logic [ByteW-1:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return w + 8'h41;
		end else if (v < 6'd52) begin
			return w + 8'h47;
		end else if (v < 6'd62) begin
			return w - 8'h04;
		end else if (v == 6'd62) begin
			return 8'h2b;
		end else begin
			return 8'h2f;
		end
	endfunction

endpackage

/* hw/rtl/b64e_byte_if.sv */
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

/* hw/rtl/b64e_char_if.sv */
interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_last;

	modport source (output valid, output out_char, output out_last, input ready);
	modport sink (input valid, input out_char, input out_last, output ready);
endinterface

/* hw/rtl/b64e_group.sv */
module b64e_group (
	input  logic            clk,
	input  logic            arst_n,
	b64e_byte_if.sink       raw,
	input  logic            load_ok,
	output logic            load,
	output b64e_pkg::grp_t  grp
);
	import b64e_pkg::*;

	logic        valid_s0;
	logic [7:0]  byte_s0;
	logic        fin_s0;
	logic [1:0]  cnt_q;
	logic [15:0] held_q;

	logic        produces;
	logic        adv;
	logic [15:0] pair;
	logic [23:0] word;

	assign pair = {held_q[7:0], byte_s0};
	assign word = {held_q, byte_s0};

	// A group completes on the third byte or on the final byte.
	assign produces = fin_s0 || (cnt_q == 2'd2);
	assign adv      = valid_s0 && (!produces || load_ok);
	assign load     = adv && produces;
	assign raw.ready = !valid_s0 || adv;

	always_comb begin
		grp.fin   = fin_s0;
		grp.chars = '0;
		grp.n_m1  = 2'd3;
		unique case (cnt_q)
			2'd1: begin
				grp.chars[0] = sym(pair[15:10]);
				grp.chars[1] = sym(pair[9:4]);
				grp.chars[2] = sym({pair[3:0], 2'b00});
				grp.n_m1     = 2'd2;
			end
			2'd2: begin
				grp.chars[0] = sym(word[23:18]);
				grp.chars[1] = sym(word[17:12]);
				grp.chars[2] = sym(word[11:6]);
				grp.chars[3] = sym(word[5:0]);
				grp.n_m1     = 2'd3;
			end
			default: begin
				grp.chars[0] = sym(byte_s0[7:2]);
				grp.chars[1] = sym({byte_s0[1:0], 4'b0000});
				grp.n_m1     = 2'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (raw.valid && raw.ready) begin
				valid_s0 <= 1'b1;
			end else if (adv) begin
				valid_s0 <= 1'b0;
			end
			if (adv) begin
				if (produces || cnt_q == 2'd3) begin
					cnt_q <= produces ? 2'd0 : 2'd1;
				end else begin
					cnt_q <= cnt_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			byte_s0 <= raw.data_byte;
			fin_s0  <= raw.final_byte;
		end
		if (adv && !produces) begin
			if (cnt_q == 2'd1) begin
				held_q <= pair;
			end else begin
				held_q <= {8'h00, byte_s0};
			end
		end
	end

endmodule

/* hw/rtl/b64e_serial.sv */
module b64e_serial (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  b64e_pkg::grp_t  grp,
	output logic            load_ok,
	b64e_char_if.source     enc
);
	import b64e_pkg::*;

	logic                          busy_s1;
	logic [GroupN-1:0][ByteW-1:0]  chars_s1;
	logic [1:0]                    n_m1_s1;
	logic                          fin_s1;
	logic [1:0]                    idx_q;
	logic                          take;
	logic                          done;

	assign take = enc.valid && enc.ready;
	assign done = take && (idx_q == n_m1_s1);

	// A new group may be loaded in the same cycle the last character transfers.
	assign load_ok = !busy_s1 || done;

	assign enc.valid    = busy_s1;
	assign enc.out_char = chars_s1[idx_q];
	assign enc.out_last = fin_s1 && (idx_q == n_m1_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				busy_s1 <= 1'b1;
				idx_q   <= 2'd0;
			end else if (done) begin
				busy_s1 <= 1'b0;
				idx_q   <= 2'd0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chars_s1 <= grp.chars;
			n_m1_s1  <= grp.n_m1;
			fin_s1   <= grp.fin;
		end
	end

endmodule

/* hw/rtl/base64_stream_encoder_top.sv */
// Unpadded base64 encoder. Raw bytes enter on raw, one per transfer, with
// final_byte set on the last byte of a message; characters leave on enc, one
// per transfer, with out_last set on the last character of the message. A byte
// is taken into an input register, encoded there against the held bytes of the
// current group, and a finished group of two to four characters is loaded into
// a result register that drives enc one character per cycle while enc.ready
// is high. The byte that completes a group passes through the input register
// and then into the result register before its first character appears.
// Bytes that only fill a group are taken one per cycle; the one-character
// output register sets the sustained rate, and a new group loads in the same
// cycle the previous group's last character transfers.
module base64_stream_encoder_top (
	input  logic         clk,
	input  logic         arst_n,
	b64e_byte_if.sink    raw,
	b64e_char_if.source  enc
);
	import b64e_pkg::*;

	grp_t grp;
	logic load;
	logic load_ok;

	b64e_group u_group (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw),
		.load_ok (load_ok),
		.load    (load),
		.grp     (grp)
	);

	b64e_serial u_serial (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.grp     (grp),
		.load_ok (load_ok),
		.enc     (enc)
	);

endmodule

/* hw/rtl/b64e_checker.sv */
module b64e_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       raw_valid,
	input logic       raw_ready,
	input logic       enc_valid,
	input logic       enc_ready,
	input logic [7:0] enc_char,
	input logic       enc_last
);

	// A character that is offered and not taken stays put.
	a_enc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		enc_valid && !enc_ready |=> enc_valid && $stable(enc_char) && $stable(enc_last))
		else $error("enc payload changed while stalled");

	// With no group in the result register, the input side never stalls.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!enc_valid |-> raw_ready)
		else $error("raw stalled while output side idle");

	// A new run of characters is caused by a byte transfer: the byte passes through
	// the input register before its group is loaded into the result register.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(enc_valid) |-> $past(raw_valid && raw_ready, 2))
		else $error("characters appeared without a byte transfer");

endmodule

bind base64_stream_encoder_top b64e_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.raw_valid (raw.valid),
	.raw_ready (raw.ready),
	.enc_valid (enc.valid),
	.enc_ready (enc.ready),
	.enc_char  (enc.out_char),
	.enc_last  (enc.out_last)
);
